### src/rtfp_pkg.sv
// Package for the radar target frame parser.
// Holds frame byte codes and the record struct; no dependencies.
package rtfp_pkg;
  localparam logic [7:0] TailA = 8'h55;
  localparam logic [7:0] TailB = 8'hCC;
  localparam logic [7:0] Hdr0 = 8'hAA;
  localparam logic [7:0] Hdr1 = 8'hFF;
  localparam logic [7:0] Hdr2 = 8'h03;
  localparam logic [7:0] Hdr3 = 8'h00;
  localparam logic [15:0] SignBit = 16'h8000;
  localparam logic [15:0] MagMask = 16'h7FFF;
  localparam int RecBytes = 8;

  typedef struct packed {
    logic [1:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] velocity;
    logic [15:0] gate_resolution;
    logic [15:0] range_dist;
    logic        present;
    logic        header_seen;
    logic [1:0]  present_total;
    logic        last;
  } result_t;

  // Little-endian sign-magnitude word to two's complement.
  function automatic logic [15:0] sm_to_tc(input logic [15:0] w);
    logic [15:0] mag;
    mag = w & MagMask;
    return ((w & SignBit) != 16'd0) ? (16'd0 - mag) : mag;
  endfunction
endpackage

### src/rtfp_if.sv
// Valid/ready channel interfaces for the frame parser.
// Depends on rtfp_pkg for the result struct.
interface rtfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rtfp_out_if;
  logic              valid;
  logic              ready;
  rtfp_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rtfp_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module rtfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### src/rtfp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// No dependencies; used by the frame parser top level.
module rtfp_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] n_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  logic [31:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic        busy_q, busy_d;
  logic [31:0] trial;
  always_comb begin
    rem_d = rem_q; root_d = root_q; bit_d = bit_q; busy_d = busy_q;
    trial = root_q + bit_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d = n_i; root_d = '0; bit_d = 32'h4000_0000; busy_d = 1'b1;
    end else if (busy_q) begin
      if (bit_q == 32'd0) begin
        busy_d = 1'b0; done_o = 1'b1;
      end else begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end
  assign root_o = root_q[15:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else busy_q <= busy_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; bit_q <= bit_d;
  end
endmodule

### src/radar_target_frame_parser.sv
// Radar target frame parser: line store in RAM, header scan, record decode.
// Depends on rtfp_pkg, rtfp_if, rtfp_ram and rtfp_isqrt.
// Flow: input bytes are taken only while idle. After a frame end the header
// scan issues one RAM read per cycle, then each decoded record is read (its 8
// bytes) and its square root taken, then the result items (MAX_TARGETS of
// them) go out one per cycle while the receiver is ready.
// Reset clears the fill index and all record slots; tcnt_q resets to MAX_TARGETS.
module radar_target_frame_parser #(
  parameter int BUFFER_DEPTH = 64,
  parameter int MAX_TARGETS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  rtfp_in_if.sink    in_if,
  rtfp_out_if.source out_if
);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int IW = AW + 1;
  localparam logic [1:0] MaxT = 2'(MAX_TARGETS);

  localparam logic [2:0] SIdle = 3'd0, SScan = 3'd1, SRec = 3'd2, SSqrt = 3'd3,
                         SEmit = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] fill_q, fill_d, len_q, len_d;
  logic [7:0]    prev_q, prev_d;
  logic [1:0]    tcnt_q;
  logic [IW-1:0] ptr_q, ptr_d;       // address issued this cycle
  logic          rv_q, rv_d;         // read data valid next cycle
  logic [IW-1:0] rptr_q, rptr_d;     // address of data now returning
  logic [23:0]   win_q, win_d;       // last three scanned bytes
  logic [IW-1:0] hdr_q, hdr_d;
  logic          seen_q, seen_d;
  logic [1:0]    t_q, t_d;
  logic [63:0]   recb_q, recb_d;
  logic [1:0]    k_q, k_d;
  logic [15:0] rx_q [3], ry_q [3], rs_q [3], rr_q [3], rd_q [3];
  logic [2:0]  rvld_q;
  logic        wr_x, wr_d2;
  logic [15:0] nx, ny, ns, nr;
  logic [IW:0] rec_end;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic          sq_start, sq_done;
  logic [15:0]   sq_root;
  logic [31:0]   sq_n;
  logic signed [15:0] sx, sy;

  rtfp_ram #(.Width(8), .Depth(BUFFER_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_if.rx_byte),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  rtfp_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .n_i(sq_n), .done_o(sq_done), .root_o(sq_root)
  );

  assign in_if.ready = (state_q == SIdle);
  assign we = in_if.valid && in_if.ready;
  assign waddr = fill_q[AW-1:0];
  assign raddr = ptr_q[AW-1:0];

  assign nx = rtfp_pkg::sm_to_tc(recb_q[15:0]);
  assign ny = rtfp_pkg::sm_to_tc(recb_q[31:16]);
  assign ns = rtfp_pkg::sm_to_tc(recb_q[47:32]);
  assign nr = recb_q[63:48];
  assign sx = nx;
  assign sy = ny;
  assign sq_n = 32'(sx * sx) + 32'(sy * sy);

  // One past the last byte of record t_q; fixed while that record is read.
  assign rec_end = (IW+1)'(hdr_q) + (IW+1)'(4 + rtfp_pkg::RecBytes) +
                   (IW+1)'({t_q, 3'b000});

  always_comb begin
    state_d = state_q; fill_d = fill_q; len_d = len_q; prev_d = prev_q;
    ptr_d = ptr_q; rv_d = 1'b0; rptr_d = ptr_q; win_d = win_q; hdr_d = hdr_q;
    seen_d = seen_q; t_d = t_q; recb_d = recb_q; k_d = k_q;
    sq_start = 1'b0; wr_x = 1'b0; wr_d2 = 1'b0;
    case (state_q)
      SIdle: begin
        if (we) begin
          prev_d = in_if.rx_byte;
          if (fill_q + IW'(1) >= IW'(BUFFER_DEPTH)) begin
            fill_d = '0;
          end else if (fill_q >= IW'(1) && prev_q == rtfp_pkg::TailA &&
                       in_if.rx_byte == rtfp_pkg::TailB) begin
            len_d = fill_q + IW'(1);
            fill_d = '0;
            ptr_d = '0; rv_d = 1'b0; seen_d = 1'b0; t_d = '0; win_d = '0;
            state_d = SScan;
          end else begin
            fill_d = fill_q + IW'(1);
          end
        end
      end
      SScan: begin
        // Issue one read per cycle; compare the window as bytes return.
        if (ptr_q < len_q) begin
          ptr_d = ptr_q + IW'(1); rv_d = 1'b1;
        end
        rptr_d = ptr_q;
        if (rv_q) begin
          win_d = {win_q[15:0], rdata};
          if (rptr_q >= IW'(3) && win_q == {rtfp_pkg::Hdr0, rtfp_pkg::Hdr1,
              rtfp_pkg::Hdr2} && rdata == rtfp_pkg::Hdr3) begin
            seen_d = 1'b1;
            hdr_d = rptr_q - IW'(3);
            ptr_d = rptr_q + IW'(1);
            rv_d = 1'b0;
            state_d = SRec;
          end
        end
        if (state_d == SScan && !rv_q && ptr_q >= len_q) begin
          k_d = '0; state_d = SEmit;
        end
      end
      SRec: begin
        // ptr_q points at the first byte of record t_q on entry.
        if (t_q >= tcnt_q || t_q >= MaxT || rec_end > (IW+1)'(len_q)) begin
          if (!rv_q) begin
            k_d = '0; state_d = SEmit;
          end
        end else begin
          if (ptr_q - hdr_q - IW'(4) - IW'({t_q, 3'b000}) < IW'(rtfp_pkg::RecBytes)
              && !(rv_q && rptr_q - hdr_q - IW'(4) - IW'({t_q, 3'b000}) ==
                   IW'(rtfp_pkg::RecBytes - 1))) begin
            ptr_d = ptr_q + IW'(1); rv_d = 1'b1;
          end
          rptr_d = ptr_q;
        end
        if (rv_q) begin
          recb_d = {rdata, recb_q[63:8]};
          if (rptr_q - hdr_q - IW'(4) - IW'({t_q, 3'b000}) ==
              IW'(rtfp_pkg::RecBytes - 1)) begin
            rv_d = 1'b0;
            ptr_d = rptr_q + IW'(1);
            state_d = SSqrt;
          end
        end
      end
      SSqrt: begin
        if (!rv_q) begin
          // First cycle here launches the root; rv_q marks it launched.
          sq_start = 1'b1; rv_d = 1'b1; wr_x = 1'b1;
        end else begin
          rv_d = 1'b1;
          if (sq_done) begin
            wr_d2 = 1'b1; rv_d = 1'b0;
            t_d = t_q + 2'd1;
            state_d = SRec;
          end
        end
      end
      SEmit: begin
        if (out_if.ready) begin
          if (k_q == MaxT - 2'd1) state_d = SIdle;
          else k_d = k_q + 2'd1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  logic [1:0] total;
  always_comb begin
    total = '0;
    for (int i = 0; i < MAX_TARGETS; i++)
      if (rvld_q[i] && 2'(i) < tcnt_q) total = total + 2'd1;
  end

  assign out_if.valid = (state_q == SEmit);
  assign out_if.data.slot = k_q;
  assign out_if.data.pos_x = rx_q[k_q];
  assign out_if.data.pos_y = ry_q[k_q];
  assign out_if.data.velocity = rs_q[k_q];
  assign out_if.data.gate_resolution = rr_q[k_q];
  assign out_if.data.range_dist = rd_q[k_q];
  assign out_if.data.present = rvld_q[k_q];
  assign out_if.data.header_seen = seen_q;
  assign out_if.data.present_total = total;
  assign out_if.data.last = (k_q == MaxT - 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; fill_q <= '0; tcnt_q <= MaxT; rv_q <= 1'b0; k_q <= '0;
      rvld_q <= '0; seen_q <= 1'b0; t_q <= '0;
      for (int i = 0; i < 3; i++) begin
        rx_q[i] <= '0; ry_q[i] <= '0; rs_q[i] <= '0; rr_q[i] <= '0; rd_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; fill_q <= fill_d; rv_q <= rv_d; k_q <= k_d;
      seen_q <= seen_d; t_q <= t_d;
      if (cfg_we_i) tcnt_q <= (cfg_wdata_i > MaxT) ? MaxT : cfg_wdata_i;
      if (wr_x) begin
        rx_q[t_q] <= nx; ry_q[t_q] <= ny; rs_q[t_q] <= ns; rr_q[t_q] <= nr;
        rvld_q[t_q] <= (nr != 16'd0);
      end
      if (wr_d2) rd_q[t_q] <= sq_root;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d; prev_q <= prev_d; ptr_q <= ptr_d; rptr_q <= rptr_d;
    win_q <= win_d; hdr_q <= hdr_d; recb_q <= recb_d;
  end
endmodule
